@@ hw/rtl/ftcd_pkg.sv @@
// Shared types and constants of the tile cache directory.
`default_nettype none

package ftcd_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = 1;

  localparam logic [2:0] REG_BANDS_IN_USE       = 3'd0;
  localparam logic [2:0] REG_BLOCKS_ACROSS      = 3'd1;
  localparam logic [2:0] REG_BLOCKS_DOWN        = 3'd2;
  localparam logic [2:0] REG_CACHE_CAPACITY     = 3'd3;
  localparam logic [2:0] REG_WRITE_BACK_ENABLED = 3'd4;

  localparam logic [2:0] RESET_BANDS_IN_USE   = 3'd4;
  localparam logic [6:0] RESET_BLOCKS_ACROSS  = 7'd64;
  localparam logic [6:0] RESET_BLOCKS_DOWN    = 7'd64;
  localparam logic [4:0] RESET_CACHE_CAPACITY = 5'd16;

  typedef struct packed {
    logic [2:0] bands_in_use;
    logic [6:0] blocks_across;
    logic [6:0] blocks_down;
    logic [4:0] cache_capacity;
    logic       write_back_enabled;
  } cfg_t;

  typedef struct packed {
    logic [1:0] band;
    logic [5:0] col;
    logic [5:0] row;
    logic       oor;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic       victim_valid;
    logic [1:0] victim_band;
    logic [5:0] victim_col;
    logic [5:0] victim_row;
    logic       write_back;
    logic       out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ftcd_if.sv @@
// Request and response channel interfaces of the tile cache directory.
`default_nettype none

interface ftcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_band;
  logic [5:0] req_col;
  logic [5:0] req_row;

  modport source (output valid, req_band, req_col, req_row, input ready);
  modport sink (input valid, req_band, req_col, req_row, output ready);
endinterface

interface ftcd_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [3:0] slot;
  logic       victim_valid;
  logic [1:0] victim_band;
  logic [5:0] victim_col;
  logic [5:0] victim_row;
  logic       write_back;
  logic       out_of_range;

  modport source (output valid, hit, slot, victim_valid, victim_band, victim_col,
                  victim_row, write_back, out_of_range, input ready);
  modport sink (input valid, hit, slot, victim_valid, victim_band, victim_col,
                victim_row, write_back, out_of_range, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ftcd_front.sv @@
// Front end: accepts requests, checks range and forms the directory index.
`default_nettype none

module ftcd_front #(
  parameter int MAX_BANDS      = 4,
  parameter int MAX_BLOCK_COLS = 64,
  parameter int MAX_BLOCK_ROWS = 64,
  parameter int IW             = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ftcd_pkg::cfg_t cfg,
  input  wire logic          clearing,
  ftcd_req_if.sink           req,
  output logic               push_valid,
  input  wire logic          push_ready,
  output ftcd_pkg::item_t    push_item,
  output logic [IW-1:0]      push_idx
);

  localparam int PD = MAX_BANDS * MAX_BLOCK_ROWS;
  localparam int PW = (PD > 1) ? $clog2(PD) : 1;
  localparam logic [2:0] BANDS_LIM = (MAX_BANDS > 7) ? 3'd7 : 3'(MAX_BANDS);
  localparam logic [6:0] COLS_LIM  = (MAX_BLOCK_COLS > 127) ? 7'd127 : 7'(MAX_BLOCK_COLS);
  localparam logic [6:0] ROWS_LIM  = (MAX_BLOCK_ROWS > 127) ? 7'd127 : 7'(MAX_BLOCK_ROWS);

  logic [2:0]      nb;
  logic [6:0]      nx;
  logic [6:0]      ny;
  logic            oor_in;
  logic [PW-1:0]   part_in;
  logic            fv;
  ftcd_pkg::item_t item;
  logic [PW-1:0]   part;
  logic            take;

  always_comb begin
    nb = (cfg.bands_in_use > BANDS_LIM) ? BANDS_LIM : cfg.bands_in_use;
    nx = (cfg.blocks_across > COLS_LIM) ? COLS_LIM : cfg.blocks_across;
    ny = (cfg.blocks_down > ROWS_LIM) ? ROWS_LIM : cfg.blocks_down;
    oor_in = ({1'b0, req.req_band} >= nb) || ({1'b0, req.req_col} >= nx) ||
             ({1'b0, req.req_row} >= ny);
    part_in = PW'(req.req_band) * PW'(MAX_BLOCK_ROWS) + PW'(req.req_row);
  end

  assign req.ready = !clearing && (!fv || push_ready);
  assign take = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      if (take) begin
        fv <= 1'b1;
      end else if (push_ready) begin
        fv <= 1'b0;
      end
    end
    if (take) begin
      item.band <= req.req_band;
      item.col  <= req.req_col;
      item.row  <= req.req_row;
      item.oor  <= oor_in;
      part      <= oor_in ? '0 : part_in;
    end
  end

  assign push_valid = fv;
  assign push_item  = item;
  assign push_idx   = item.oor ? '0 :
                      IW'(part) * IW'(MAX_BLOCK_COLS) + IW'(item.col);

endmodule

`default_nettype wire

@@ hw/rtl/ftcd_queue.sv @@
// Short queue of classified requests between the front and back ends.
`default_nettype none

module ftcd_queue #(
  parameter int IW = 14
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ftcd_pkg::item_t push_item,
  input  wire logic [IW-1:0]   push_idx,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output ftcd_pkg::item_t      pop_item,
  output logic [IW-1:0]        pop_idx
);

  ftcd_pkg::item_t            items [ftcd_pkg::QUEUE_DEPTH];
  logic [IW-1:0]              idxs  [ftcd_pkg::QUEUE_DEPTH];
  logic [ftcd_pkg::QPW-1:0]   wr_ptr;
  logic [ftcd_pkg::QPW-1:0]   rd_ptr;
  logic [ftcd_pkg::QPW:0]     count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = count != (ftcd_pkg::QPW + 1)'(ftcd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = items[rd_ptr];
  assign pop_idx    = idxs[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      items[wr_ptr] <= push_item;
      idxs[wr_ptr]  <= push_idx;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ftcd_back.sv @@
// Back end: directory memory, slot table, FIFO replacement and result register.
`default_nettype none

module ftcd_back #(
  parameter int CACHE_SLOTS = 16,
  parameter int DEPTH       = 16384,
  parameter int IW          = 14
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ftcd_pkg::cfg_t  cfg,
  output logic                 clearing,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire ftcd_pkg::item_t q_item,
  input  wire logic [IW-1:0]   q_idx,
  ftcd_rsp_if.source           rsp
);

  localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int FW = $clog2(CACHE_SLOTS + 1);
  localparam logic [4:0] CAP_LIM = (CACHE_SLOTS > 31) ? 5'd31 : 5'(CACHE_SLOTS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_EVICT} state_t;

  typedef struct packed {
    logic [1:0]    band;
    logic [5:0]    col;
    logic [5:0]    row;
    logic [IW-1:0] idx;
  } entry_t;

  state_t          state;
  logic [IW-1:0]   clr_cnt;
  logic [FW-1:0]   filled;
  logic [SW-1:0]   vp;
  ftcd_pkg::item_t cur;
  logic [IW-1:0]   cur_idx;
  logic [IW-1:0]   vic_idx;
  logic            fwd_clear;
  logic            out_valid;
  ftcd_pkg::rsp_t  rsp_r;
  entry_t          slots [CACHE_SLOTS];

  logic [SW:0]     dir_mem [DEPTH];
  logic [SW:0]     dir_q;
  logic            we;
  logic [IW-1:0]   wa;
  logic [SW:0]     wd;
  logic            rd_en;

  logic [4:0]      cap;
  logic            full;
  logic            hit_now;
  logic            miss;
  logic            proceed;
  logic [SW-1:0]   slot;
  logic [SW-1:0]   vp_next;
  entry_t          vic;
  ftcd_pkg::rsp_t  rsp_next;

  always_comb begin
    cap = (cfg.cache_capacity > CAP_LIM) ? CAP_LIM : cfg.cache_capacity;
    if (cap == 5'd0) begin
      cap = 5'd1;
    end
    full    = filled >= FW'(cap);
    hit_now = dir_q[SW] && !fwd_clear;
    miss    = !cur.oor && !hit_now;
    proceed = (state == S_LOOK) && (!out_valid || rsp.ready);
    slot    = full ? vp : SW'(filled);
    vp_next = ((FW'(vp) + FW'(1)) == filled) ? '0 : vp + 1'b1;
    vic     = slots[vp];

    rsp_next = '0;
    if (cur.oor) begin
      rsp_next.out_of_range = 1'b1;
    end else if (hit_now) begin
      rsp_next.hit  = 1'b1;
      rsp_next.slot = 4'(dir_q[SW-1:0]);
    end else begin
      rsp_next.slot = 4'(slot);
      if (full) begin
        rsp_next.victim_valid = 1'b1;
        rsp_next.victim_band  = vic.band;
        rsp_next.victim_col   = vic.col;
        rsp_next.victim_row   = vic.row;
        rsp_next.write_back   = cfg.write_back_enabled;
      end
    end

    q_ready = (state == S_IDLE) || (state == S_EVICT);
    rd_en   = q_ready && q_valid;

    we = 1'b0;
    wa = cur_idx;
    wd = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
      end
      S_LOOK: begin
        we = proceed && miss;
        wd = {1'b1, slot};
      end
      S_EVICT: begin
        we = 1'b1;
        wa = vic_idx;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dir_mem[wa] <= wd;
    end
    if (rd_en) begin
      dir_q <= dir_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      filled    <= '0;
      vp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (proceed) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            cur_idx   <= q_idx;
            fwd_clear <= 1'b0;
            state     <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (proceed) begin
            rsp_r <= rsp_next;
            if (miss) begin
              slots[slot] <= '{band: cur.band, col: cur.col, row: cur.row, idx: cur_idx};
            end
            if (miss && full) begin
              vic_idx <= vic.idx;
              vp      <= vp_next;
              state   <= S_EVICT;
            end else begin
              state <= S_IDLE;
            end
            if (miss && !full) begin
              filled <= filled + 1'b1;
            end
          end
        end
        S_EVICT: begin
          if (q_valid) begin
            cur       <= q_item;
            cur_idx   <= q_idx;
            fwd_clear <= q_idx == vic_idx;
            state     <= S_LOOK;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign clearing         = state == S_CLEAR;
  assign rsp.valid        = out_valid;
  assign rsp.hit          = rsp_r.hit;
  assign rsp.slot         = rsp_r.slot;
  assign rsp.victim_valid = rsp_r.victim_valid;
  assign rsp.victim_band  = rsp_r.victim_band;
  assign rsp.victim_col   = rsp_r.victim_col;
  assign rsp.victim_row   = rsp_r.victim_row;
  assign rsp.write_back   = rsp_r.write_back;
  assign rsp.out_of_range = rsp_r.out_of_range;

endmodule

`default_nettype wire

@@ hw/rtl/fifo_tile_cache_directory_top.sv @@
// Top level of the tile cache directory: configuration registers and block wiring.
// Requests pass the front-end register, the queue, the directory read and the result
// register; the back end takes a new request only after the previous lookup is done.
// A miss that evicts writes the directory twice, overlapped with the next lookup.
// Reset is synchronous; afterwards a clearing pass writes all MAX_BANDS * MAX_BLOCK_ROWS *
// MAX_BLOCK_COLS directory entries (16384 by default) before requests are accepted.
`default_nettype none

module fifo_tile_cache_directory_top #(
  parameter int MAX_BANDS      = 4,
  parameter int MAX_BLOCK_COLS = 64,
  parameter int MAX_BLOCK_ROWS = 64,
  parameter int CACHE_SLOTS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  ftcd_req_if.sink         req,
  ftcd_rsp_if.source       rsp
);

  localparam int DEPTH = MAX_BANDS * MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ftcd_pkg::cfg_t  cfg;
  logic            clearing;
  logic            push_valid;
  logic            push_ready;
  ftcd_pkg::item_t push_item;
  logic [IW-1:0]   push_idx;
  logic            pop_valid;
  logic            pop_ready;
  ftcd_pkg::item_t pop_item;
  logic [IW-1:0]   pop_idx;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bands_in_use       <= ftcd_pkg::RESET_BANDS_IN_USE;
      cfg.blocks_across      <= ftcd_pkg::RESET_BLOCKS_ACROSS;
      cfg.blocks_down        <= ftcd_pkg::RESET_BLOCKS_DOWN;
      cfg.cache_capacity     <= ftcd_pkg::RESET_CACHE_CAPACITY;
      cfg.write_back_enabled <= 1'b0;
    end else if (wr) begin
      case (paddr[4:2])
        ftcd_pkg::REG_BANDS_IN_USE:       cfg.bands_in_use       <= pwdata[2:0];
        ftcd_pkg::REG_BLOCKS_ACROSS:      cfg.blocks_across      <= pwdata[6:0];
        ftcd_pkg::REG_BLOCKS_DOWN:        cfg.blocks_down        <= pwdata[6:0];
        ftcd_pkg::REG_CACHE_CAPACITY:     cfg.cache_capacity     <= pwdata[4:0];
        ftcd_pkg::REG_WRITE_BACK_ENABLED: cfg.write_back_enabled <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ftcd_pkg::REG_BANDS_IN_USE:       prdata = 32'(cfg.bands_in_use);
      ftcd_pkg::REG_BLOCKS_ACROSS:      prdata = 32'(cfg.blocks_across);
      ftcd_pkg::REG_BLOCKS_DOWN:        prdata = 32'(cfg.blocks_down);
      ftcd_pkg::REG_CACHE_CAPACITY:     prdata = 32'(cfg.cache_capacity);
      ftcd_pkg::REG_WRITE_BACK_ENABLED: prdata = 32'(cfg.write_back_enabled);
      default:                          prdata = '0;
    endcase
  end

  ftcd_front #(
    .MAX_BANDS      (MAX_BANDS),
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
    .MAX_BLOCK_ROWS (MAX_BLOCK_ROWS),
    .IW             (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_idx   (push_idx)
  );

  ftcd_queue #(
    .IW (IW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_idx   (push_idx),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .pop_idx    (pop_idx)
  );

  ftcd_back #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .DEPTH       (DEPTH),
    .IW          (IW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_item   (pop_item),
    .q_idx    (pop_idx),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
